// ----- src/pil_pkg.sv -----
// Package for the positional insert/erase list: field widths, codes and shared types.
`default_nettype none

package pil_pkg;

	localparam int FUNC_W   = 2;
	localparam int INDEX_W  = 5;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam int DEFAULT_CAPACITY  = 16;
	localparam int DEFAULT_WORD_BITS = 32;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Shift command broadcast from the controller to every cell.
	typedef struct packed {
		logic               ins;
		logic               del;
		logic [INDEX_W-1:0] pos;
	} shift_cmd_t;

endpackage : pil_pkg

`default_nettype wire

// ----- src/pil_if.sv -----
// Valid/ready channel interfaces for requests and results of the list.
`default_nettype none

interface pil_req_if
	import pil_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [INDEX_W-1:0]  index;
	logic [VALUE_W-1:0]  value;

	modport source (output valid, output func, output index, output value, input ready);
	modport sink (input valid, input func, input index, input value, output ready);
endinterface : pil_req_if

interface pil_rsp_if
	import pil_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  read_data;
	logic [COUNT_W-1:0]  count;

	modport source (output valid, output status, output read_data, output count, input ready);
	modport sink (input valid, input status, input read_data, input count, output ready);
endinterface : pil_rsp_if

`default_nettype wire

// ----- src/pil_cell.sv -----
// One storage cell of the list: keeps its word or takes a neighbor's or the new word.
`default_nettype none

module pil_cell
	import pil_pkg::*;
#(
	parameter int WORD_BITS = DEFAULT_WORD_BITS,
	parameter int IDX       = 0
) (
	input  wire logic                 clk,
	input  wire shift_cmd_t           cmd,
	input  wire logic [WORD_BITS-1:0] left_word,
	input  wire logic [WORD_BITS-1:0] right_word,
	input  wire logic [WORD_BITS-1:0] new_word,
	output logic      [WORD_BITS-1:0] word
);

	logic [WORD_BITS-1:0] word_q;
	int                   pos;

	assign pos  = int'(cmd.pos);
	assign word = word_q;

	always_ff @(posedge clk) begin
		if (cmd.ins && IDX > pos) begin
			word_q <= left_word;
		end else if (cmd.ins && IDX == pos) begin
			word_q <= new_word;
		end else if (cmd.del && IDX >= pos) begin
			word_q <= right_word;
		end
	end

endmodule : pil_cell

`default_nettype wire

// ----- src/pil_ctrl.sv -----
// List controller: holds the entry count, checks ranges and issues shift commands.
`default_nettype none

module pil_ctrl
	import pil_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [FUNC_W-1:0]   func,
	input  wire logic [INDEX_W-1:0]  index,
	output shift_cmd_t               cmd,
	output logic                     rd_ok,
	output logic [STATUS_W-1:0]      status,
	output logic [COUNT_W-1:0]       count_next
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cnt_d;
	logic [CMP_W-1:0] idx_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic             do_ins;
	logic             do_del;

	assign idx_ext = CMP_W'(index);
	assign cnt_ext = CMP_W'(count_q);

	always_comb begin
		status = ST_OK;
		do_ins = 1'b0;
		do_del = 1'b0;
		rd_ok  = 1'b0;
		cnt_d  = count_q;
		unique case (func)
			FUNC_INSERT: begin
				if (idx_ext > cnt_ext) begin
					status = ST_RANGE;
				end else if (count_q >= CAP_CNT) begin
					status = ST_FULL;
				end else begin
					do_ins = 1'b1;
					cnt_d  = count_q + 1'b1;
				end
			end
			FUNC_ERASE: begin
				if (idx_ext >= cnt_ext) begin
					status = ST_RANGE;
				end else begin
					do_del = 1'b1;
					cnt_d  = count_q - 1'b1;
				end
			end
			FUNC_READ: begin
				if (idx_ext >= cnt_ext) begin
					status = ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			FUNC_CLEAR: begin
				cnt_d = '0;
			end
			default: begin
				cnt_d = count_q;
			end
		endcase
	end

	assign cmd.ins    = accept && do_ins;
	assign cmd.del    = accept && do_del;
	assign cmd.pos    = index;
	assign count_next = COUNT_W'(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= cnt_d;
		end
	end

endmodule : pil_ctrl

`default_nettype wire

// ----- src/positional_insert_erase_list.sv -----
// Top level of the positional insert/erase list: cell chain, controller and result register.
//
// Requests arrive as words on the req channel (func, index, value) and each one yields
// exactly one result word on the rsp channel (status, read_data, count).
// Storage is a row of CAPACITY cells; an insert or an erase moves every affected cell
// by one place at once, each cell taking its neighbor's word.
// The result of an accepted word is registered at the accepting edge and shown in the next cycle.
// Throughput is one word per cycle, set by the shift of the whole cell row at once and
// the one-entry result register; while rsp is taken every cycle, req stays ready.
// When the receiver stalls, the result holds in its register and req drops ready until
// that result is taken; a new word is accepted in the same cycle the old result leaves.
// Reset empties the list and clears the result valid; the cell contents are not cleared
// and are never returned before being written, since reads are bounded by the count.
// Status codes: ok, position out of range, store full (range check first).
`default_nettype none

module positional_insert_erase_list
	import pil_pkg::*;
#(
	parameter int CAPACITY  = DEFAULT_CAPACITY,
	parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	pil_req_if.sink   req,
	pil_rsp_if.source rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	shift_cmd_t           cmd;
	logic                 accept;
	logic                 rd_ok;
	logic [STATUS_W-1:0]  status;
	logic [COUNT_W-1:0]   count_next;
	logic [63:0]          value_ext;
	logic [63:0]          read_ext;
	logic [WORD_BITS-1:0] new_word;
	logic [WORD_BITS-1:0] cell_word [CAPACITY];
	logic [IDX_W-1:0]     rd_sel;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [VALUE_W-1:0]   data_q;
	logic [COUNT_W-1:0]   count_q;

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign value_ext = 64'(req.value);
	assign new_word  = value_ext[WORD_BITS-1:0];

	pil_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.func       (req.func),
		.index      (req.index),
		.cmd        (cmd),
		.rd_ok      (rd_ok),
		.status     (status),
		.count_next (count_next)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] left_word;
		logic [WORD_BITS-1:0] right_word;

		if (i == 0) begin : g_first
			assign left_word = '0;
		end else begin : g_left
			assign left_word = cell_word[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_word = '0;
		end else begin : g_right
			assign right_word = cell_word[i+1];
		end

		pil_cell #(
			.WORD_BITS (WORD_BITS),
			.IDX       (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.left_word  (left_word),
			.right_word (right_word),
			.new_word   (new_word),
			.word       (cell_word[i])
		);
	end

	// The index is below the count whenever rd_ok is set, so the select stays in range.
	assign rd_sel   = IDX_W'(req.index);
	assign read_ext = rd_ok ? 64'(cell_word[rd_sel]) : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req.ready) begin
			out_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status;
			data_q   <= read_ext[VALUE_W-1:0];
			count_q  <= count_next;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.read_data = data_q;
	assign rsp.count     = count_q;

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.count == COUNT_W'(CAPACITY))
		else $error("full status reported with count below capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.func == FUNC_CLEAR |=> rsp.valid && rsp.count == '0)
		else $error("clear did not leave an empty list");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.read_data == '0)
		else $error("failed request returned nonzero read data");

endmodule : positional_insert_erase_list

`default_nettype wire
